// ===== design/dfr_pkg.sv =====
`default_nettype none
package dfr_pkg;

   localparam int unsigned DEF_COUNTER_BYTES      = 4;
   localparam int unsigned DEF_CONFIG_LIST_BYTES  = 4;
   localparam int unsigned DEF_COMMAND_LIST_BYTES = 4;

   localparam logic [7:0]  SYNC_A_BYTE  = 8'h61;
   localparam logic [7:0]  SYNC_B_BYTE  = 8'h62;
   localparam logic [7:0]  TYPE_CONFIG  = 8'h01;
   localparam logic [7:0]  TYPE_COMMAND = 8'h02;
   localparam logic [7:0]  CRC_POLY     = 8'h8C;
   localparam logic [31:0] SLOT_MASK    = 32'h07FF07FF;

   typedef enum logic [2:0] {
      KIND_COUNTER      = 3'd0,
      KIND_CONFIG_LIST  = 3'd1,
      KIND_COMMAND_LIST = 3'd2,
      KIND_COMMAND_WORD = 3'd3,
      KIND_FRAME_END    = 3'd4
   } item_kind_type;

   typedef enum logic [1:0] {
      FRAME_NONE    = 2'd0,
      FRAME_CONFIG  = 2'd1,
      FRAME_COMMAND = 2'd2
   } frame_kind_type;

   typedef enum logic [7:0] {
      PH_SYNC_A   = 8'b0000_0001,
      PH_SYNC_B   = 8'b0000_0010,
      PH_COUNTER  = 8'b0000_0100,
      PH_TYPE     = 8'b0000_1000,
      PH_CFG_LIST = 8'b0001_0000,
      PH_CMD_LIST = 8'b0010_0000,
      PH_CMD_WORD = 8'b0100_0000,
      PH_CRC      = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      item_kind_type  item_kind;
      logic [4:0]     slot_index;
      logic [31:0]    word_value;
      frame_kind_type frame_kind;
      logic           crc_ok;
   } result_type;

   // Reflected CRC-8, one bit per step.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== design/dfr_in_stage.sv =====
`default_nettype none
module dfr_in_stage
   import dfr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       take,
   output logic            byte_valid,
   output logic [7:0]      byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // Accept a new request whenever the held byte is empty or consumed now.
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule
`default_nettype wire

// ===== design/dfr_parser.sv =====
`default_nettype none
module dfr_parser
   import dfr_pkg::*;
#(
   parameter int unsigned COUNTER_BYTES      = DEF_COUNTER_BYTES,
   parameter int unsigned CONFIG_LIST_BYTES  = DEF_CONFIG_LIST_BYTES,
   parameter int unsigned COMMAND_LIST_BYTES = DEF_COMMAND_LIST_BYTES
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   output logic            res_valid,
   output result_type      res
);

   localparam logic [2:0] CNT_LEN = 3'(COUNTER_BYTES);
   localparam logic [2:0] CFG_LEN = 3'(CONFIG_LIST_BYTES);
   localparam logic [2:0] CMD_LEN = 3'(COMMAND_LIST_BYTES);

   phase_type      phase_ff, phase_in;
   logic [1:0]     pos_ff, pos_in;
   logic [4:0]     slot_ff, slot_in;
   logic [31:0]    pending_ff, pending_in;
   logic [31:0]    list_ff, list_in;
   logic [7:0]     crc_ff, crc_in;
   logic [31:0]    buf_ff, buf_in;
   frame_kind_type frame_ff, frame_in;

   logic [7:0]  crc_next;
   logic [31:0] buf_with_byte;
   logic [2:0]  pos_plus;
   logic [4:0]  first_slot;
   logic [4:0]  cur_slot;
   logic [31:0] pending_left;
   logic [31:0] masked_list;

   assign crc_next      = crc8_update(crc_ff, rx_byte);
   assign buf_with_byte = buf_ff | ({24'b0, rx_byte} << {pos_ff, 3'b000});
   assign pos_plus      = {1'b0, pos_ff} + 3'd1;
   assign masked_list   = list_ff & SLOT_MASK;

   // Lowest pending slot; zero when none is pending.
   always_comb begin
      first_slot = 5'd0;
      for (int i = 31; i >= 0; i--) begin
         if (pending_ff[i]) begin
            first_slot = 5'(i);
         end
      end
   end

   assign pending_left = (pos_ff == 2'd0) ? (pending_ff & (pending_ff - 32'd1)) : pending_ff;
   assign cur_slot     = (pos_ff == 2'd0) ? first_slot : slot_ff;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      slot_in    = slot_ff;
      pending_in = pending_ff;
      list_in    = list_ff;
      crc_in     = crc_ff;
      buf_in     = buf_ff;
      frame_in   = frame_ff;
      res_valid  = 1'b0;
      res.item_kind  = KIND_COUNTER;
      res.slot_index = 5'd0;
      res.word_value = 32'd0;
      res.frame_kind = frame_ff;
      res.crc_ok     = 1'b0;

      case (phase_ff)
         PH_SYNC_A: begin
            pos_in     = 2'd0;
            slot_in    = 5'd0;
            pending_in = 32'd0;
            buf_in     = 32'd0;
            frame_in   = FRAME_NONE;
            if (rx_byte == SYNC_A_BYTE) begin
               phase_in = PH_SYNC_B;
               crc_in   = crc8_update(8'd0, rx_byte);
            end else begin
               crc_in = 8'd0;
            end
         end
         PH_SYNC_B: begin
            if (rx_byte == SYNC_B_BYTE) begin
               phase_in = PH_COUNTER;
               crc_in   = crc_next;
            end else begin
               phase_in = PH_SYNC_A;
               crc_in   = 8'd0;
            end
         end
         PH_COUNTER: begin
            crc_in = crc_next;
            if (pos_plus >= CNT_LEN) begin
               res_valid      = 1'b1;
               res.item_kind  = KIND_COUNTER;
               res.word_value = buf_with_byte;
               pos_in   = 2'd0;
               buf_in   = 32'd0;
               phase_in = PH_TYPE;
            end else begin
               pos_in = pos_plus[1:0];
               buf_in = buf_with_byte;
            end
         end
         PH_TYPE: begin
            pos_in  = 2'd0;
            slot_in = 5'd0;
            buf_in  = 32'd0;
            if (rx_byte == TYPE_COMMAND) begin
               crc_in     = crc_next;
               frame_in   = FRAME_COMMAND;
               pending_in = masked_list;
               phase_in   = (masked_list != 32'd0) ? PH_CMD_WORD : PH_CRC;
            end else if (rx_byte == TYPE_CONFIG) begin
               crc_in     = crc_next;
               frame_in   = FRAME_CONFIG;
               pending_in = 32'd0;
               phase_in   = PH_CFG_LIST;
            end else begin
               // Drop the frame.
               crc_in     = 8'd0;
               frame_in   = FRAME_NONE;
               pending_in = 32'd0;
               phase_in   = PH_SYNC_A;
            end
         end
         PH_CFG_LIST: begin
            crc_in = crc_next;
            if (pos_plus >= CFG_LEN) begin
               res_valid      = 1'b1;
               res.item_kind  = KIND_CONFIG_LIST;
               res.word_value = buf_with_byte;
               pos_in   = 2'd0;
               buf_in   = 32'd0;
               phase_in = PH_CMD_LIST;
            end else begin
               pos_in = pos_plus[1:0];
               buf_in = buf_with_byte;
            end
         end
         PH_CMD_LIST: begin
            crc_in = crc_next;
            if (pos_plus >= CMD_LEN) begin
               res_valid      = 1'b1;
               res.item_kind  = KIND_COMMAND_LIST;
               res.word_value = buf_with_byte;
               list_in  = buf_with_byte;
               pos_in   = 2'd0;
               buf_in   = 32'd0;
               phase_in = PH_CRC;
            end else begin
               pos_in = pos_plus[1:0];
               buf_in = buf_with_byte;
            end
         end
         PH_CMD_WORD: begin
            crc_in     = crc_next;
            slot_in    = cur_slot;
            pending_in = pending_left;
            if (pos_ff == 2'd3) begin
               res_valid      = 1'b1;
               res.item_kind  = KIND_COMMAND_WORD;
               res.slot_index = cur_slot;
               res.word_value = buf_with_byte;
               pos_in = 2'd0;
               buf_in = 32'd0;
               if (pending_left == 32'd0) begin
                  phase_in = PH_CRC;
               end
            end else begin
               pos_in = pos_plus[1:0];
               buf_in = buf_with_byte;
            end
         end
         default: begin
            res_valid     = 1'b1;
            res.item_kind = KIND_FRAME_END;
            res.crc_ok    = (crc_ff == rx_byte);
            phase_in      = PH_SYNC_A;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SYNC_A;
         pos_ff     <= 2'd0;
         slot_ff    <= 5'd0;
         pending_ff <= 32'd0;
         list_ff    <= 32'd0;
         crc_ff     <= 8'd0;
         buf_ff     <= 32'd0;
         frame_ff   <= FRAME_NONE;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         slot_ff    <= slot_in;
         pending_ff <= pending_in;
         list_ff    <= list_in;
         crc_ff     <= crc_in;
         buf_ff     <= buf_in;
         frame_ff   <= frame_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/dfr_out_stage.sv =====
`default_nettype none
module dfr_out_stage
   import dfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire logic        load_valid,
   input  wire result_type  load_data,
   output logic             free,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // The register can take a new result when empty or drained this cycle.
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? load_valid : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// ===== design/debug_frame_receiver_unit.sv =====
// Debug frame receiver: parses one received byte per request ('a','b', little-endian counter,
// type byte, then config and command lists or the command words selected by the stored list,
// then a CRC-8 byte) and returns at most one response per request: a completed word or the
// frame end with its CRC check. A request is taken every cycle while responses drain; each
// byte passes from an input register through the parser into a response register, which
// holds the response until rsp_ready takes it. While a finished response waits on rsp_ready
// the input register still takes one more request, then req_ready stays low until the
// response register drains.
`default_nettype none
module debug_frame_receiver_unit
   import dfr_pkg::*;
#(
   parameter int unsigned COUNTER_BYTES      = DEF_COUNTER_BYTES,
   parameter int unsigned CONFIG_LIST_BYTES  = DEF_CONFIG_LIST_BYTES,
   parameter int unsigned COMMAND_LIST_BYTES = DEF_COMMAND_LIST_BYTES
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_item_kind,
   output logic [4:0]       rsp_slot_index,
   output logic [31:0]      rsp_word_value,
   output logic [1:0]       rsp_frame_kind,
   output logic             rsp_crc_ok
);

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       out_free;
   logic       advance;
   logic       res_valid;
   result_type res;
   result_type rsp_data;

   // Advance the held byte only when the response register can take its result.
   assign advance = byte_valid && out_free;

   dfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .take        (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   dfr_parser #(
      .COUNTER_BYTES      (COUNTER_BYTES),
      .CONFIG_LIST_BYTES  (CONFIG_LIST_BYTES),
      .COMMAND_LIST_BYTES (COMMAND_LIST_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (byte_data),
      .res_valid (res_valid),
      .res       (res)
   );

   dfr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .load_valid (res_valid),
      .load_data  (res),
      .free       (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_item_kind  = rsp_data.item_kind;
   assign rsp_slot_index = rsp_data.slot_index;
   assign rsp_word_value = rsp_data.word_value;
   assign rsp_frame_kind = rsp_data.frame_kind;
   assign rsp_crc_ok     = rsp_data.crc_ok;

endmodule
`default_nettype wire
